### rtl/core/wxrpm_pkg.sv
`default_nettype none

package wxrpm_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam logic [3:0] SEV_EXISTING = 4'd7;
    localparam logic [3:0] SEV_NEW      = 4'd8;
    localparam logic [3:0] SEV_NONE     = 4'd0;

    typedef enum logic [0:0] {
        CMD_OBSERVE  = 1'b0,
        CMD_BASELINE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        OUT_UPDATED  = 2'd0,
        OUT_INSERTED = 2'd1,
        OUT_FULL     = 2'd2,
        OUT_BASELINE = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        ST_UNKNOWN    = 2'd0,
        ST_TRUSTED    = 2'd1,
        ST_SUSPICIOUS = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        FSM_IDLE = 1'b0,
        FSM_SCAN = 1'b1
    } t_fsm;

    typedef struct packed {
        logic [63:0] size;
        logic [31:0] owner;
        logic [63:0] base;
    } t_key;

    typedef struct packed {
        logic    exec;
        logic    write;
        t_status status;
    } t_attr;

endpackage

`default_nettype wire

### rtl/core/wx_region_permission_monitor.sv
// Each transaction scans the occupied table slots, at most TABLE_DEPTH of them, in order and ends
// with a result strobe; an observe that hits stops at the first matching slot. The scan reads one
// slot per cycle from the key and attribute memories, and busy drops with the strobe, so the next
// transaction is accepted at the earliest at the edge that ends the strobe cycle.
// The receiver cannot stall. Reset clears the occupancy count and control state, not memories.
`default_nettype none

module wx_region_permission_monitor
    import wxrpm_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_command,
    input  wire logic [63:0] i_base_addr,
    input  wire logic [63:0] i_region_size,
    input  wire logic [31:0] i_owner_pid,
    input  wire logic        i_exec_flag,
    input  wire logic        i_write_flag,
    output logic             o_valid,
    output logic [1:0]       o_outcome,
    output logic [5:0]       o_entry_index,
    output logic [1:0]       o_entry_status,
    output logic             o_anomaly_flag,
    output logic [3:0]       o_anomaly_severity
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

    t_key  mem_key  [TABLE_DEPTH];
    t_attr mem_attr [TABLE_DEPTH];

    t_fsm r_state, n_state;

    t_cmd        r_cmd;
    logic [63:0] r_base;
    logic [63:0] r_size;
    logic [31:0] r_pid;
    logic        r_ex;
    logic        r_wr;

    logic [CW-1:0] r_used, n_used;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic          r_chk_valid, n_chk_valid;
    logic [IW-1:0] r_chk_idx, n_chk_idx;

    t_key  r_key_q;
    t_attr r_attr_q;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          key_we;
    logic [IW-1:0] key_waddr;
    t_key          key_wdata;
    logic          attr_we;
    logic [IW-1:0] attr_waddr;
    t_attr         attr_wdata;
    logic          s_done;
    logic          s_accept;

    logic          r_out_valid, n_out_valid;
    t_outcome      r_outcome, n_outcome;
    logic [IW-1:0] r_slot, n_slot;
    t_status       r_status, n_status;
    logic          r_flag, n_flag;
    logic [3:0]    r_sev, n_sev;

    logic    hit;
    logic    raise;
    t_status hit_status;
    logic    wx;

    assign s_accept   = start && (r_state == FSM_IDLE);
    assign hit        = (r_key_q.base == r_base) && (r_key_q.owner == r_pid);
    assign raise      = r_ex && r_wr && (!r_attr_q.exec || !r_attr_q.write);
    assign hit_status = raise ? ST_SUSPICIOUS : r_attr_q.status;
    assign wx         = r_ex && r_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FSM_IDLE;
            r_used      <= '0;
            r_rd_idx    <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_rd_idx    <= n_rd_idx;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd  <= t_cmd'(i_command);
            r_base <= i_base_addr;
            r_size <= i_region_size;
            r_pid  <= i_owner_pid;
            r_ex   <= i_exec_flag;
            r_wr   <= i_write_flag;
        end
        r_chk_idx <= n_chk_idx;
        r_outcome <= n_outcome;
        r_slot    <= n_slot;
        r_status  <= n_status;
        r_flag    <= n_flag;
        r_sev     <= n_sev;
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            mem_key[key_waddr] <= key_wdata;
        end
        if (rd_en) begin
            r_key_q <= mem_key[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (attr_we) begin
            mem_attr[attr_waddr] <= attr_wdata;
        end
        if (rd_en) begin
            r_attr_q <= mem_attr[rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FSM_IDLE: begin
                if (start) begin
                    n_state = FSM_SCAN;
                end
            end
            FSM_SCAN: begin
                if (s_done) begin
                    n_state = FSM_IDLE;
                end
            end
            default: n_state = FSM_IDLE;
        endcase
    end

    always_comb begin
        rd_en       = 1'b0;
        rd_addr     = r_rd_idx[IW-1:0];
        key_we      = 1'b0;
        key_waddr   = r_used[IW-1:0];
        key_wdata   = '{size: r_size, owner: r_pid, base: r_base};
        attr_we     = 1'b0;
        attr_waddr  = r_chk_idx;
        attr_wdata  = '{exec: r_ex, write: r_wr, status: hit_status};
        s_done      = 1'b0;
        n_used      = r_used;
        n_rd_idx    = r_rd_idx;
        n_chk_valid = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_out_valid = 1'b0;
        n_outcome   = r_outcome;
        n_slot      = r_slot;
        n_status    = r_status;
        n_flag      = r_flag;
        n_sev       = r_sev;

        unique case (r_state)
            FSM_IDLE: begin
                n_rd_idx = '0;
            end
            FSM_SCAN: begin
                if (r_chk_valid && (r_cmd == CMD_OBSERVE) && hit) begin
                    // First matching slot: update its permissions and report.
                    attr_we     = 1'b1;
                    s_done      = 1'b1;
                    n_out_valid = 1'b1;
                    n_outcome   = OUT_UPDATED;
                    n_slot      = r_chk_idx;
                    n_status    = hit_status;
                    n_flag      = raise;
                    n_sev       = raise ? SEV_EXISTING : SEV_NONE;
                end else begin
                    if (r_chk_valid && (r_cmd == CMD_BASELINE)
                        && (r_attr_q.status == ST_UNKNOWN)) begin
                        attr_we    = 1'b1;
                        attr_wdata = '{exec: r_attr_q.exec, write: r_attr_q.write,
                                       status: ST_TRUSTED};
                    end
                    if (r_rd_idx < r_used) begin
                        rd_en       = 1'b1;
                        n_chk_valid = 1'b1;
                        n_chk_idx   = r_rd_idx[IW-1:0];
                        n_rd_idx    = r_rd_idx + CW'(1);
                    end else if (!r_chk_valid) begin
                        s_done      = 1'b1;
                        n_out_valid = 1'b1;
                        n_slot      = '0;
                        n_status    = ST_UNKNOWN;
                        n_flag      = 1'b0;
                        n_sev       = SEV_NONE;
                        if (r_cmd == CMD_BASELINE) begin
                            n_outcome = OUT_BASELINE;
                        end else if (r_used == DEPTH_CNT) begin
                            n_outcome = OUT_FULL;
                        end else begin
                            key_we     = 1'b1;
                            attr_we    = 1'b1;
                            attr_waddr = r_used[IW-1:0];
                            attr_wdata = '{exec: r_ex, write: r_wr,
                                           status: wx ? ST_SUSPICIOUS : ST_UNKNOWN};
                            n_used     = r_used + CW'(1);
                            n_outcome  = OUT_INSERTED;
                            n_slot     = r_used[IW-1:0];
                            n_status   = wx ? ST_SUSPICIOUS : ST_UNKNOWN;
                            n_flag     = wx;
                            n_sev      = wx ? SEV_NEW : SEV_NONE;
                        end
                    end
                end
            end
            default: begin
                n_rd_idx = '0;
            end
        endcase
    end

    assign busy               = (r_state != FSM_IDLE);
    assign o_valid            = r_out_valid;
    assign o_outcome          = r_outcome;
    assign o_entry_index      = 6'(r_slot);
    assign o_entry_status     = r_status;
    assign o_anomaly_flag     = r_flag;
    assign o_anomaly_severity = r_sev;

    a_done_strobes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("Transaction finished without a result strobe.");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("Result strobe lasted more than one cycle.");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= DEPTH_CNT)
        else $error("Occupancy count exceeds the table depth.");

    a_anomaly_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_anomaly_flag) |-> (o_entry_status == ST_SUSPICIOUS))
        else $error("Anomaly reported on an entry that is not suspicious.");

endmodule

`default_nettype wire

### bench/tb_wx_region_permission_monitor.sv
module tb_wx_region_permission_monitor;
    timeunit 1ns;
    timeprecision 1ps;

    import wxrpm_pkg::*;

    localparam int POOL_KEYS      = 80;
    localparam int RANDOM_ITEMS   = 1430;
    localparam int DRAIN_CYCLES   = TABLE_DEPTH_DEF + 8;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        t_outcome    outcome;
        logic [5:0]  index;
        t_status     status;
        logic        flag;
        logic [3:0]  severity;
    } t_region_verdict;

    class wx_table_scoreboard;
        logic [63:0]     slot_base  [TABLE_DEPTH_DEF];
        logic [63:0]     slot_size  [TABLE_DEPTH_DEF];
        logic [31:0]     slot_owner [TABLE_DEPTH_DEF];
        logic            slot_exec  [TABLE_DEPTH_DEF];
        logic            slot_write [TABLE_DEPTH_DEF];
        t_status         slot_state [TABLE_DEPTH_DEF];
        int unsigned     used_slots;
        t_region_verdict pending_verdicts[$];
        int unsigned     outcome_count[4];
        int unsigned     alert_total;
        int unsigned     mismatch_count;

        function new();
            used_slots     = 0;
            alert_total    = 0;
            mismatch_count = 0;
            foreach (outcome_count[k]) outcome_count[k] = 0;
        endfunction

        function void record_request(logic cmd, logic [63:0] addr, logic [63:0] size,
                                     logic [31:0] pid, logic ex, logic wr);
            t_region_verdict v;
            int              hit;
            v.outcome  = OUT_BASELINE;
            v.index    = '0;
            v.status   = ST_UNKNOWN;
            v.flag     = 1'b0;
            v.severity = SEV_NONE;
            hit        = -1;
            if (cmd == CMD_BASELINE) begin
                for (int i = 0; i < used_slots; i++) begin
                    if (slot_state[i] == ST_UNKNOWN) slot_state[i] = ST_TRUSTED;
                end
            end else begin
                for (int i = 0; i < used_slots; i++) begin
                    if (hit < 0 && slot_base[i] == addr && slot_owner[i] == pid) hit = i;
                end
                if (hit >= 0) begin
                    v.outcome = OUT_UPDATED;
                    v.index   = hit[5:0];
                    v.flag    = ex && wr && !(slot_exec[hit] && slot_write[hit]);
                    if (v.flag) begin
                        slot_state[hit] = ST_SUSPICIOUS;
                        v.severity      = SEV_EXISTING;
                    end
                    slot_exec[hit]  = ex;
                    slot_write[hit] = wr;
                    v.status        = slot_state[hit];
                end else if (used_slots >= TABLE_DEPTH_DEF) begin
                    v.outcome = OUT_FULL;
                end else begin
                    v.outcome              = OUT_INSERTED;
                    v.index                = used_slots[5:0];
                    v.flag                 = ex && wr;
                    v.status               = v.flag ? ST_SUSPICIOUS : ST_UNKNOWN;
                    v.severity             = v.flag ? SEV_NEW : SEV_NONE;
                    slot_base[used_slots]  = addr;
                    slot_size[used_slots]  = size;
                    slot_owner[used_slots] = pid;
                    slot_exec[used_slots]  = ex;
                    slot_write[used_slots] = wr;
                    slot_state[used_slots] = v.status;
                    used_slots++;
                end
            end
            outcome_count[v.outcome]++;
            if (v.flag) alert_total++;
            pending_verdicts.push_back(v);
        endfunction

        function void check_verdict(logic [1:0] outcome, logic [5:0] index,
                                    logic [1:0] status, logic flag, logic [3:0] severity);
            t_region_verdict v;
            if (pending_verdicts.size() == 0) begin
                $error("result with no transaction pending: outcome %0d", outcome);
                mismatch_count++;
                return;
            end
            v = pending_verdicts.pop_front();
            if (outcome !== v.outcome) begin
                $error("outcome: expected %0d, got %0d", v.outcome, outcome);
                mismatch_count++;
            end
            if (index !== v.index) begin
                $error("entry_index: expected %0d, got %0d", v.index, index);
                mismatch_count++;
            end
            if (status !== v.status) begin
                $error("entry_status: expected %0d, got %0d", v.status, status);
                mismatch_count++;
            end
            if (flag !== v.flag) begin
                $error("anomaly_flag: expected %0d, got %0d", v.flag, flag);
                mismatch_count++;
            end
            if (severity !== v.severity) begin
                $error("anomaly_severity: expected %0d, got %0d", v.severity, severity);
                mismatch_count++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_command;
    logic [63:0] i_base_addr;
    logic [63:0] i_region_size;
    logic [31:0] i_owner_pid;
    logic        i_exec_flag;
    logic        i_write_flag;
    logic        o_valid;
    logic [1:0]  o_outcome;
    logic [5:0]  o_entry_index;
    logic [1:0]  o_entry_status;
    logic        o_anomaly_flag;
    logic [3:0]  o_anomaly_severity;

    wx_table_scoreboard region_table = new();
    logic [63:0]        pool_base [POOL_KEYS];
    logic [31:0]        pool_pid  [POOL_KEYS];
    bit                 no_idle = 1'b0;
    int unsigned        quiet_cycles = 0;

    wx_region_permission_monitor dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_command          (i_command),
        .i_base_addr        (i_base_addr),
        .i_region_size      (i_region_size),
        .i_owner_pid        (i_owner_pid),
        .i_exec_flag        (i_exec_flag),
        .i_write_flag       (i_write_flag),
        .o_valid            (o_valid),
        .o_outcome          (o_outcome),
        .o_entry_index      (o_entry_index),
        .o_entry_status     (o_entry_status),
        .o_anomaly_flag     (o_anomaly_flag),
        .o_anomaly_severity (o_anomaly_severity)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                region_table.record_request(i_command, i_base_addr, i_region_size,
                                            i_owner_pid, i_exec_flag, i_write_flag);
            end
            if (o_valid) begin
                region_table.check_verdict(o_outcome, o_entry_index, o_entry_status,
                                           o_anomaly_flag, o_anomaly_severity);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Start stays high from one transaction to the next when no gap is chosen.
    task automatic issue_region(logic cmd, logic [63:0] addr, logic [63:0] size,
                                logic [31:0] pid, logic ex, logic wr);
        int unsigned roll;
        int unsigned gap;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 45) begin
            gap = 0;
        end else if (roll < 85) begin
            gap = $urandom_range(1, 3);
        end else if (roll < 97) begin
            gap = $urandom_range(4, 12);
        end else begin
            gap = $urandom_range(30, 120);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command     <= cmd;
        i_base_addr   <= addr;
        i_region_size <= size;
        i_owner_pid   <= pid;
        i_exec_flag   <= ex;
        i_write_flag  <= wr;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    initial begin
        int unsigned live;
        int unsigned roll;
        int unsigned k;
        logic [63:0] addr_sel;
        logic [31:0] pid_sel;

        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_command     <= CMD_OBSERVE;
        i_base_addr   <= '0;
        i_region_size <= '0;
        i_owner_pid   <= '0;
        i_exec_flag   <= 1'b0;
        i_write_flag  <= 1'b0;

        // Some keys share a base address or an owner with their neighbor.
        for (int p = 0; p < POOL_KEYS; p++) begin
            pool_base[p] = {$urandom, $urandom};
            pool_pid[p]  = $urandom;
            if (p > 0 && $urandom_range(0, 4) == 0) begin
                pool_base[p] = pool_base[p - 1];
            end else if (p > 0 && $urandom_range(0, 4) == 0) begin
                pool_pid[p] = pool_pid[p - 1];
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue_region(CMD_BASELINE, '1, '1, '1, 1'b1, 1'b1);
        issue_region(CMD_OBSERVE, '0, '0, '0, 1'b0, 1'b0);
        issue_region(CMD_OBSERVE, '1, '1, '1, 1'b1, 1'b1);
        issue_region(CMD_OBSERVE, '0, 64'h1000, '1, 1'b1, 1'b0);
        issue_region(CMD_OBSERVE, '1, 64'h2000, '0, 1'b0, 1'b1);
        issue_region(CMD_BASELINE, '0, '0, '0, 1'b0, 1'b0);
        issue_region(CMD_OBSERVE, '0, 64'h55AA, '0, 1'b1, 1'b0);
        issue_region(CMD_OBSERVE, '0, '0, '0, 1'b1, 1'b1);
        issue_region(CMD_OBSERVE, '0, '1, '0, 1'b1, 1'b1);
        issue_region(CMD_OBSERVE, '1, '0, '1, 1'b1, 1'b1);
        issue_region(CMD_OBSERVE, '1, '0, '1, 1'b0, 1'b0);
        issue_region(CMD_OBSERVE, '1, '0, '1, 1'b1, 1'b1);
        issue_region(CMD_OBSERVE, 64'h8000_0000_0000_0000, 64'h4000, 32'h8000_0000,
                     1'b0, 1'b0);
        issue_region(CMD_OBSERVE, 64'h8000_0000_0000_0000, '0, 32'h8000_0000, 1'b0, 1'b1);
        issue_region(CMD_OBSERVE, 64'h8000_0000_0000_0000, '0, 32'h8000_0000, 1'b1, 1'b1);
        issue_region(CMD_BASELINE, '0, '0, '0, 1'b0, 1'b0);
        issue_region(CMD_OBSERVE, '0, '0, '1, 1'b1, 1'b1);

        // The set of live keys grows slowly, so the table runs partly filled for
        // a long stretch before it fills and misses start to report a full table.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle  = (n % 200) < 40;
            live     = (8 + n / 20 < POOL_KEYS) ? 8 + n / 20 : POOL_KEYS;
            roll     = $urandom_range(0, 99);
            k        = $urandom_range(0, live - 1);
            addr_sel = pool_base[k];
            pid_sel  = pool_pid[k];
            if (roll < 3) begin
                addr_sel = {$urandom, $urandom};
                pid_sel  = $urandom;
            end
            issue_region(roll >= 92 ? CMD_BASELINE : CMD_OBSERVE, addr_sel,
                         {$urandom, $urandom}, pid_sel,
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end

        start <= 1'b0;
        while (region_table.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d inserts, %0d updates, %0d table-full and %0d baseline transactions.",
                 region_table.outcome_count[OUT_INSERTED], region_table.outcome_count[OUT_UPDATED],
                 region_table.outcome_count[OUT_FULL], region_table.outcome_count[OUT_BASELINE]);
        $display("The table reached %0d occupied slots and %0d anomalies were raised.",
                 region_table.used_slots, region_table.alert_total);
        if (region_table.mismatch_count == 0 && region_table.pending_verdicts.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
